[rtl/core/bwmm_pkg.sv]
// Shared types and constants of the box window mean and moment block.
// No dependencies; every other file of the block but bwmm_ram imports it.
`default_nettype none

package bwmm_pkg;

    // Ring of recent columns.
    localparam int RING_DEPTH = 64;
    localparam int RING_AW    = $clog2(RING_DEPTH);

    // A line ends at this many samples even without a last marker.
    localparam logic [15:0] MAX_LINE = 16'd65535;

    // Field widths.
    localparam int SUM_W  = 24;
    localparam int SQ_W   = 40;
    localparam int POS_W  = 16;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_WIDTH  = 2'd2;

    // Output modes; any other code behaves as the second moment.
    localparam logic [1:0] MODE_MOMENT = 2'd0;
    localparam logic [1:0] MODE_VAR    = 2'd1;
    localparam logic [1:0] MODE_SIGMA  = 2'd2;

    // Effective configuration, zero sizes already mapped to one.
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] height;
        logic [5:0] width;
        logic [4:0] half;
    } t_cfg;

    // One output position waiting to be computed.
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] len;
        logic             last;
        logic             short_line;
    } t_job;

    // A pointer that walks the line and bounces off both ends.
    typedef struct packed {
        logic             dir;
        logic [POS_W-1:0] pos;
    } t_walk;

endpackage

`default_nettype wire

[rtl/core/bwmm_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module bwmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Storage write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/core/bwmm_queue.sv]
// Two-entry job queue between the front and the back.
// Depends on bwmm_pkg for the job type.
`default_nettype none

module bwmm_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire bwmm_pkg::t_job i_job,
    input  wire logic          i_pop,
    output logic               o_empty,
    output logic               o_full,
    output bwmm_pkg::t_job     o_head
);
    import bwmm_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_head  = r_mem[r_rp];

    // Pointer and fill count update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_job;
                r_wp        <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/bwmm_front.sv]
// Front end: accepts sample beats, stores them in the column ring and
// queues output positions. Depends on bwmm_pkg.
`default_nettype none

module bwmm_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire bwmm_pkg::t_cfg              i_cfg,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic                        i_last_in,
    input  wire logic                        i_back_reading,
    input  wire logic                        i_q_empty,
    input  wire logic                        i_q_full,
    output logic                             o_push,
    output bwmm_pkg::t_job                   o_job,
    output logic                             o_ring_we,
    output logic [bwmm_pkg::RING_AW-1:0]     o_ring_addr
);
    import bwmm_pkg::*;

    logic [POS_W-1:0] r_count;
    logic [POS_W-1:0] r_emit;
    logic             r_flush;
    logic [POS_W-1:0] r_flen;
    logic             r_fshort;

    logic             acc;
    logic [POS_W-1:0] n_count;
    logic             line_end;
    logic             due;
    logic             flush_push;

    // A new beat is taken only when nothing still reads the ring.
    assign o_ready  = i_rst_n && !r_flush && i_q_empty && !i_back_reading;
    assign acc      = i_valid && o_ready;
    assign n_count  = r_count + 16'd1;
    assign line_end = i_last_in || (n_count >= MAX_LINE);
    assign due      = {1'b0, r_count} >= ({1'b0, r_emit} + 17'(i_cfg.half));

    assign o_ring_we   = acc;
    assign o_ring_addr = r_count[RING_AW-1:0];

    assign flush_push = r_flush && !i_q_full && (r_emit != r_flen);

    // Job selection: at most one position per beat mid line, all the rest at the end.
    always_comb begin
        o_push = 1'b0;
        o_job  = '0;
        if (flush_push) begin
            o_push          = 1'b1;
            o_job.pos       = r_emit;
            o_job.len       = r_flen;
            o_job.last      = (r_emit + 16'd1 == r_flen);
            o_job.short_line = r_fshort;
        end else if (acc && !line_end && due) begin
            o_push    = 1'b1;
            o_job.pos = r_emit;
            o_job.len = n_count;
        end
    end

    // Line position bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_emit  <= '0;
            r_flush <= 1'b0;
        end else if (r_flush) begin
            if (r_emit == r_flen) begin
                r_flush <= 1'b0;
                r_count <= '0;
                r_emit  <= '0;
            end else if (flush_push) begin
                r_emit <= r_emit + 16'd1;
            end
        end else if (acc) begin
            if (line_end) begin
                r_flush  <= 1'b1;
                r_flen   <= n_count;
                r_fshort <= (n_count <= 16'(i_cfg.width));
            end else begin
                r_count <= n_count;
                if (due) begin
                    r_emit <= r_emit + 16'd1;
                end
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/bwmm_back.sv]
// Back end: sums the mirrored window from the ring, divides by the area and
// forms the moment, variance or sigma. Depends on bwmm_pkg.
`default_nettype none

module bwmm_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire bwmm_pkg::t_cfg              i_cfg,
    input  wire logic                        i_q_empty,
    input  wire bwmm_pkg::t_job              i_q_job,
    output logic                             o_q_pop,
    output logic [bwmm_pkg::RING_AW-1:0]     o_rd_addr,
    input  wire logic [bwmm_pkg::SUM_W-1:0]  i_rd_sum,
    input  wire logic [bwmm_pkg::SQ_W-1:0]   i_rd_sq,
    output logic                             o_reading,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [bwmm_pkg::SUM_W-1:0]       o_mean_out,
    output logic [bwmm_pkg::SQ_W-1:0]        o_moment_out,
    output logic                             o_last_out,
    output logic                             o_short_line
);
    import bwmm_pkg::*;

    localparam int DIV_W = 54;
    localparam int X_W   = 62;

    localparam logic DIR_UP   = 1'b0;
    localparam logic DIR_DOWN = 1'b1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_DRAIN = 4'd2;
    localparam logic [3:0] S_LOAD  = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_MSQ   = 4'd5;
    localparam logic [3:0] S_VAR   = 4'd6;
    localparam logic [3:0] S_SQRT  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    // One step along the line, bouncing off either end without repeating it.
    function automatic t_walk walk_step(t_walk cur, logic [POS_W-1:0] len);
        t_walk nx;
        nx = cur;
        if (len == 16'd1) begin
            nx.pos = '0;
        end else if (cur.dir == DIR_UP) begin
            if (cur.pos == len - 16'd1) begin
                nx.pos = cur.pos - 16'd1;
                nx.dir = DIR_DOWN;
            end else begin
                nx.pos = cur.pos + 16'd1;
            end
        end else begin
            if (cur.pos == '0) begin
                nx.pos = 16'd1;
                nx.dir = DIR_UP;
            end else begin
                nx.pos = cur.pos - 16'd1;
            end
        end
        return nx;
    endfunction

    logic [3:0]       r_st;
    t_job             r_job;
    t_walk            r_right;
    t_walk            r_left;
    logic [5:0]       r_k;
    logic             r_rdv;
    logic [29:0]      r_s;
    logic [45:0]      r_s2;
    logic             r_dsel;
    logic [5:0]       r_cnt;
    logic [DIV_W-1:0] r_num;
    logic [14:0]      r_rem;
    logic [SUM_W-1:0] r_mean;
    logic [DIV_W-1:0] r_mom;
    logic [39:0]      r_msq;
    logic [X_W-1:0]   r_x;
    logic [30:0]      r_root;
    logic [32:0]      r_srem;

    t_walk            n_right;
    t_walk            n_left;
    logic [13:0]      area;
    logic [DIV_W-1:0] div_num;
    logic [15:0]      div_t;
    logic             div_ge;
    logic [DIV_W-1:0] n_num;
    logic [14:0]      n_rem;
    logic [DIV_W-1:0] var_val;
    logic [34:0]      sq_rem2;
    logic [34:0]      sq_trial;
    logic             sq_ge;
    logic [30:0]      n_root;
    logic [32:0]      n_srem;
    logic             out_free;

    assign o_reading = (r_st == S_READ) || (r_st == S_DRAIN);
    assign o_q_pop   = (r_st == S_IDLE) && !i_q_empty;
    assign out_free  = !o_valid || i_ready;

    // Ring read address: the center first, then right and left in turn.
    assign n_right = walk_step(r_right, r_job.len);
    assign n_left  = walk_step(r_left, r_job.len);
    always_comb begin
        if (r_k == 6'd0) begin
            o_rd_addr = r_job.pos[RING_AW-1:0];
        end else if (r_k[0]) begin
            o_rd_addr = n_right.pos[RING_AW-1:0];
        end else begin
            o_rd_addr = n_left.pos[RING_AW-1:0];
        end
    end

    // Area divisor and rounded numerators.
    assign area    = 14'(i_cfg.height) * 14'(i_cfg.width);
    assign div_num = r_dsel ? (DIV_W'({r_s2, 8'h00}) + DIV_W'(area >> 1))
                            : (DIV_W'({r_s, 8'h00}) + DIV_W'(area >> 1));

    // One restoring division step.
    assign div_t  = {r_rem, r_num[DIV_W-1]};
    assign div_ge = div_t >= 16'(area);
    assign n_num  = {r_num[DIV_W-2:0], div_ge};
    assign n_rem  = div_ge ? 15'(div_t - 16'(area)) : div_t[14:0];

    // Variance clamped at zero.
    assign var_val = (r_mom > DIV_W'(r_msq)) ? (r_mom - DIV_W'(r_msq)) : '0;

    // One square root digit.
    assign sq_rem2  = {r_srem, r_x[X_W-1 -: 2]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign sq_ge    = sq_rem2 >= sq_trial;
    assign n_root   = {r_root[29:0], sq_ge};
    assign n_srem   = sq_ge ? 33'(sq_rem2 - sq_trial) : sq_rem2[32:0];

    // Sequencer for one output position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_rdv   <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            // A taken result empties the output register unless a new one loads it.
            if (o_valid && i_ready && (r_st != S_OUT)) begin
                o_valid <= 1'b0;
            end
            if (r_rdv) begin
                r_s  <= r_s + 30'(i_rd_sum);
                r_s2 <= r_s2 + 46'(i_rd_sq);
            end
            r_rdv <= (r_st == S_READ);
            case (r_st)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_job   <= i_q_job;
                        r_right <= '{dir: DIR_UP, pos: i_q_job.pos};
                        r_left  <= '{dir: DIR_DOWN, pos: i_q_job.pos};
                        r_k     <= '0;
                        r_s     <= '0;
                        r_s2    <= '0;
                        r_st    <= S_READ;
                    end
                end
                S_READ: begin
                    if (r_k != 6'd0) begin
                        if (r_k[0]) begin
                            r_right <= n_right;
                        end else begin
                            r_left <= n_left;
                        end
                    end
                    if (r_k == {i_cfg.half, 1'b0}) begin
                        r_st <= S_DRAIN;
                    end else begin
                        r_k <= r_k + 6'd1;
                    end
                end
                S_DRAIN: begin
                    r_dsel <= 1'b0;
                    r_st   <= S_LOAD;
                end
                S_LOAD: begin
                    r_num <= div_num;
                    r_rem <= '0;
                    r_cnt <= '0;
                    r_st  <= S_DIV;
                end
                S_DIV: begin
                    r_num <= n_num;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(DIV_W - 1)) begin
                        if (!r_dsel) begin
                            r_mean <= (|n_num[DIV_W-1:SUM_W]) ? '1 : n_num[SUM_W-1:0];
                            r_dsel <= 1'b1;
                            r_st   <= S_LOAD;
                        end else begin
                            r_mom <= n_num;
                            r_st  <= S_MSQ;
                        end
                    end
                end
                S_MSQ: begin
                    r_msq <= 40'((49'(r_mean) * 49'(r_mean) + 49'd128) >> 8);
                    r_st  <= S_VAR;
                end
                S_VAR: begin
                    if (i_cfg.mode == MODE_SIGMA) begin
                        r_x    <= {var_val, 8'h00};
                        r_root <= '0;
                        r_srem <= '0;
                        r_cnt  <= '0;
                        r_st   <= S_SQRT;
                    end else begin
                        if (i_cfg.mode == MODE_VAR) begin
                            r_mom <= var_val;
                        end
                        r_st <= S_OUT;
                    end
                end
                S_SQRT: begin
                    r_x    <= {r_x[X_W-3:0], 2'b00};
                    r_root <= n_root;
                    r_srem <= n_srem;
                    r_cnt  <= r_cnt + 6'd1;
                    if (r_cnt == 6'(X_W / 2 - 1)) begin
                        r_mom <= DIV_W'(n_root) + DIV_W'(n_srem > 33'(n_root));
                        r_st  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        o_valid      <= 1'b1;
                        o_mean_out   <= r_mean;
                        o_moment_out <= (|r_mom[DIV_W-1:SQ_W]) ? '1 : r_mom[SQ_W-1:0];
                        o_last_out   <= r_job.last;
                        o_short_line <= r_job.short_line;
                        r_st         <= S_IDLE;
                    end
                end
                default: begin
                    r_st <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/box_window_mean_moment.sv]
// Box window mean and second moment over one image line: the top level.
// Depends on bwmm_pkg, bwmm_ram, bwmm_queue, bwmm_front and bwmm_back.
//
// Each input beat carries one column sum and column sum of squares of a line.
// A result for position p leaves once window_width/2 further samples have
// arrived; the beat marked last flushes all remaining positions. Results are
// computed one at a time by a shared sequencer, and each takes the position from
// the queue, makes width/2*2 + 1 ring reads, drains the last read, runs two
// divisions by the window area and forms the variance, plus a square root in
// sigma mode, and then loads the output register. A new input beat is taken
// once the queue is empty, no line flush is pending and the previous beat's
// positions have been read out of the ring.
`default_nettype none

module box_window_mean_moment (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [1:0]                 i_cfg_idx,
    input  wire logic [7:0]                 i_cfg_data,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [bwmm_pkg::SUM_W-1:0] i_col_sum,
    input  wire logic [bwmm_pkg::SQ_W-1:0]  i_col_sum_sq,
    input  wire logic                       i_last_in,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [bwmm_pkg::SUM_W-1:0]      o_mean_out,
    output logic [bwmm_pkg::SQ_W-1:0]       o_moment_out,
    output logic                            o_last_out,
    output logic                            o_short_line
);
    import bwmm_pkg::*;

    logic [1:0]       r_mode;
    logic [7:0]       r_height;
    logic [5:0]       r_width;

    t_cfg             cfg;
    logic             q_push;
    logic             q_pop;
    logic             q_empty;
    logic             q_full;
    t_job             q_in;
    t_job             q_head;
    logic             ring_we;
    logic [RING_AW-1:0] ring_waddr;
    logic [RING_AW-1:0] ring_raddr;
    logic [SUM_W-1:0] rd_sum;
    logic [SQ_W-1:0]  rd_sq;
    logic             back_reading;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_MOMENT;
            r_height <= 8'd1;
            r_width  <= 6'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:   r_mode   <= i_cfg_data[1:0];
                CFG_HEIGHT: r_height <= i_cfg_data;
                CFG_WIDTH:  r_width  <= i_cfg_data[5:0];
                default:    r_mode   <= r_mode;
            endcase
        end
    end

    // Zero sizes act as one.
    always_comb begin
        cfg.mode   = r_mode;
        cfg.height = (r_height == '0) ? 8'd1 : r_height;
        cfg.width  = (r_width == '0) ? 6'd1 : r_width;
        cfg.half   = cfg.width[5:1];
    end

    bwmm_ram #(.WIDTH(SUM_W), .DEPTH(RING_DEPTH)) u_sum_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (i_col_sum),
        .i_raddr (ring_raddr),
        .o_rdata (rd_sum)
    );

    bwmm_ram #(.WIDTH(SQ_W), .DEPTH(RING_DEPTH)) u_square_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (i_col_sum_sq),
        .i_raddr (ring_raddr),
        .o_rdata (rd_sq)
    );

    bwmm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_last_in      (i_last_in),
        .i_back_reading (back_reading),
        .i_q_empty      (q_empty),
        .i_q_full       (q_full),
        .o_push         (q_push),
        .o_job          (q_in),
        .o_ring_we      (ring_we),
        .o_ring_addr    (ring_waddr)
    );

    bwmm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_head  (q_head)
    );

    bwmm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_q_empty    (q_empty),
        .i_q_job      (q_head),
        .o_q_pop      (q_pop),
        .o_rd_addr    (ring_raddr),
        .i_rd_sum     (rd_sum),
        .i_rd_sq      (rd_sq),
        .o_reading    (back_reading),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_mean_out   (o_mean_out),
        .o_moment_out (o_moment_out),
        .o_last_out   (o_last_out),
        .o_short_line (o_short_line)
    );

endmodule

`default_nettype wire
